[design/mfp_pkg.sv]
// ----------------------------------------------------------------------------
// mfp_pkg
// Shared types, register indexes and constant tables of the multi-function
// peripheral (interrupt controller, four timers, pin edges, receive port).
// ----------------------------------------------------------------------------
package mfp_pkg;

    typedef logic [7:0] t_byte;

    // number of implemented registers; indexes 24..31 are unused
    localparam int REG_COUNT = 24;

    // register indexes (bus address >> 1)
    localparam logic [4:0] R_GPIP  = 5'd0;
    localparam logic [4:0] R_AER   = 5'd1;
    localparam logic [4:0] R_IERA  = 5'd3;
    localparam logic [4:0] R_IERB  = 5'd4;
    localparam logic [4:0] R_IPRA  = 5'd5;
    localparam logic [4:0] R_IPRB  = 5'd6;
    localparam logic [4:0] R_ISRA  = 5'd7;
    localparam logic [4:0] R_ISRB  = 5'd8;
    localparam logic [4:0] R_IMRA  = 5'd9;
    localparam logic [4:0] R_IMRB  = 5'd10;
    localparam logic [4:0] R_VR    = 5'd11;
    localparam logic [4:0] R_TACR  = 5'd12;
    localparam logic [4:0] R_TBCR  = 5'd13;
    localparam logic [4:0] R_TCDCR = 5'd14;
    localparam logic [4:0] R_TADR  = 5'd15;
    localparam logic [4:0] R_TBDR  = 5'd16;
    localparam logic [4:0] R_TCDR  = 5'd17;
    localparam logic [4:0] R_TDDR  = 5'd18;
    localparam logic [4:0] R_RSR   = 5'd21;
    localparam logic [4:0] R_TSR   = 5'd22;
    localparam logic [4:0] R_UDR   = 5'd23;

    // item function codes
    typedef enum logic [2:0] {
        FN_WRITE = 3'd0,
        FN_READ  = 3'd1,
        FN_PIN   = 3'd2,
        FN_KEY   = 3'd3,
        FN_ACK   = 3'd4,
        FN_TICK  = 3'd5
    } t_func;

    // register file contents after reset
    localparam t_byte RESET_TABLE [REG_COUNT] = '{
        8'h7B, 8'h06, 8'h00, 8'h18, 8'h3E, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h18, 8'h3E, 8'h40, 8'h08, 8'h01, 8'h77, 8'h01,
        8'h0D, 8'hC8, 8'h14, 8'h00, 8'h88, 8'h01, 8'h81, 8'h00
    };

    // interrupt source of timers A..D (index 0 is timer A)
    localparam logic [3:0][3:0] TIMER_SRC = {4'd4, 4'd5, 4'd8, 4'd13};
    // interrupt source of each input pin; pin 5 has none
    localparam logic [7:0][3:0] PIN_SRC =
        {4'd15, 4'd14, 4'd0, 4'd6, 4'd3, 4'd2, 4'd1, 4'd0};
    localparam logic [7:0] PIN_HAS_SRC = 8'b1101_1111;
    // prescaler divide ratio per 3-bit code
    localparam logic [7:0][7:0] PRESCALE_DIV =
        {8'd200, 8'd100, 8'd64, 8'd50, 8'd16, 8'd10, 8'd4, 8'd0};

    localparam logic [3:0] SRC_RX_FULL   = 4'd12;
    localparam logic [2:0] EVENT_PIN     = 3'd4;
    localparam logic [3:0] TACR_EVENT    = 4'd8;

    localparam t_byte GPIP_READ_SET  = 8'h23;
    localparam t_byte GPIP_PIN_MASK  = 8'hD8;
    localparam t_byte TSR_KEEP       = 8'hD0;
    localparam t_byte TSR_WR_MASK    = 8'h2F;
    localparam t_byte TSR_EN_CLEAR   = 8'h50;
    localparam t_byte TSR_ALWAYS     = 8'h80;
    localparam t_byte TSR_READ_CLEAR = 8'h40;
    localparam t_byte RSR_FULL       = 8'h80;
    localparam t_byte RSR_READ_CLEAR = 8'hC0;
    localparam t_byte VR_BASE_MASK   = 8'hF0;
    localparam t_byte UNUSED_READ    = 8'hFF;

    // one input beat
    typedef struct packed {
        logic [2:0] func;
        logic [5:0] address;
        t_byte      write_data;
        logic [2:0] pin_index;
        logic       pin_level;
    } t_item;

    // one result beat
    typedef struct packed {
        t_byte read_data;
        logic  key_accepted;
        t_byte vector;
        logic  vector_valid;
        logic  irq;
    } t_result;

endpackage

[design/multifunction_peripheral_irq_timers.sv]
// ----------------------------------------------------------------------------
// multifunction_peripheral_irq_timers
// Multi-function peripheral: 24 byte registers, 16-source interrupt
// controller, four down-counting timers, pin edge logic and a receive port.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one operation per beat:
//   bus write, bus read, pin change, received key byte, interrupt acknowledge
//   or one peripheral clock tick. Output channel (o_out_valid / i_out_stall)
//   returns exactly one result beat per input beat, in order.
//   Path: a beat is held in the input register, then applied by the core
//   and stored in the result register, which drives the output port.
//   Throughput: one beat per cycle unless stalled; the whole update is one
//   pass of logic between the input register and the result register.
//   Reset (synchronous, active low): register file takes its default table,
//   timer reloads and prescalers clear, all timers stopped, both pipeline
//   registers empty.
//   When the receiver stalls, the result register holds its beat; the input
//   register takes at most one more beat, and o_in_stall is high in the same
//   cycle as i_out_stall whenever both registers hold a beat.
// ----------------------------------------------------------------------------
module multifunction_peripheral_irq_timers (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_in_func,
    input  logic [5:0] i_in_address,
    input  logic [7:0] i_in_write_data,
    input  logic [2:0] i_in_pin_index,
    input  logic       i_in_pin_level,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_read_data,
    output logic       o_out_key_accepted,
    output logic [7:0] o_out_vector,
    output logic       o_out_vector_valid,
    output logic       o_out_irq
);
    import mfp_pkg::*;

    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    out_ready;
    logic    fire;
    t_result core_result;
    t_result out_result;

    assign in_item = '{
        func:       i_in_func,
        address:    i_in_address,
        write_data: i_in_write_data,
        pin_index:  i_in_pin_index,
        pin_level:  i_in_pin_level
    };

    // beat moves from input register to result register
    assign fire = held_valid && out_ready;

    mfp_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_item     (in_item),
        .i_fire     (fire),
        .o_in_stall (o_in_stall),
        .o_valid    (held_valid),
        .o_item     (held_item)
    );

    mfp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (held_item),
        .o_result (core_result)
    );

    mfp_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (fire),
        .i_result    (core_result),
        .i_out_stall (i_out_stall),
        .o_ready     (out_ready),
        .o_out_valid (o_out_valid),
        .o_result    (out_result)
    );

    assign o_out_read_data    = out_result.read_data;
    assign o_out_key_accepted = out_result.key_accepted;
    assign o_out_vector       = out_result.vector;
    assign o_out_vector_valid = out_result.vector_valid;
    assign o_out_irq          = out_result.irq;

endmodule

[design/mfp_in_stage.sv]
// ----------------------------------------------------------------------------
// mfp_in_stage
// Input register: holds one accepted beat until the core consumes it.
// ----------------------------------------------------------------------------
module mfp_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  mfp_pkg::t_item i_item,
    input  logic          i_fire,
    output logic          o_in_stall,
    output logic          o_valid,
    output mfp_pkg::t_item o_item
);
    import mfp_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  accept;

    // stall only while a held beat cannot move on
    assign o_in_stall = r_valid && !i_fire;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept || (r_valid && !i_fire);
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[design/mfp_core.sv]
// ----------------------------------------------------------------------------
// mfp_core
// Register file, timer and prescaler state, and the single-pass update that
// applies one beat and forms its result.
// ----------------------------------------------------------------------------
module mfp_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  mfp_pkg::t_item   i_item,
    output mfp_pkg::t_result o_result
);
    import mfp_pkg::*;

    t_byte       r_rf     [REG_COUNT];
    t_byte       n_rf     [REG_COUNT];
    t_byte       r_reload [4];
    t_byte       n_reload [4];
    t_byte       r_psc    [4];
    t_byte       n_psc    [4];
    logic  [3:0] r_on;
    logic  [3:0] n_on;

    logic  [4:0]  idx;
    logic         odd;
    t_byte        d;
    logic  [4:0]  tofs;
    logic  [2:0]  codes [4];
    logic  [15:0] raise;
    logic  [15:0] act;
    logic  [15:0] wrd;
    logic  [15:0] pend;
    logic  [3:0]  hi;
    t_byte        cnt;
    t_byte        tval;
    logic         pin_fall;
    t_result      res;

    // timer counts down, reloading when it would reach zero
    function automatic t_byte tmr_next(input t_byte cur, input t_byte rel);
        t_byte dec;
        dec = cur - 8'd1;
        return (dec == 8'd0) ? rel : dec;
    endfunction

    assign idx = i_item.address[5:1];
    assign odd = i_item.address[0];
    assign d   = i_item.write_data;

    // prescaler code of each timer
    assign codes[0] = r_rf[R_TACR][2:0];
    assign codes[1] = r_rf[R_TBCR][2:0];
    assign codes[2] = r_rf[R_TCDCR][6:4];
    assign codes[3] = r_rf[R_TCDCR][2:0];

    // active sources before this beat
    assign act = {r_rf[R_IPRA], r_rf[R_IPRB]} & {r_rf[R_IMRA], r_rf[R_IMRB]}
               & ~{r_rf[R_ISRA], r_rf[R_ISRB]};

    // next state and result
    always_comb begin
        n_rf     = r_rf;
        n_reload = r_reload;
        n_psc    = r_psc;
        n_on     = r_on;
        raise    = '0;
        tofs     = idx - R_TADR;
        hi       = '0;
        wrd      = '0;
        cnt      = '0;
        tval     = '0;
        pin_fall = 1'b0;
        res      = '0;

        case (i_item.func)
            FN_WRITE: begin
                if (odd && (int'(idx) < REG_COUNT)) begin
                    case (idx)
                        R_GPIP, R_UDR: begin
                        end
                        R_IERA, R_IERB: begin
                            n_rf[idx]        = d;
                            n_rf[idx + 5'd2] = r_rf[idx + 5'd2] & d;
                        end
                        R_IPRA, R_IPRB, R_ISRA, R_ISRB: begin
                            n_rf[idx] = r_rf[idx] & d;
                        end
                        R_TADR, R_TBDR, R_TCDR, R_TDDR: begin
                            n_rf[idx]            = d;
                            n_reload[tofs[1:0]]  = d;
                        end
                        R_TACR: begin
                            n_rf[idx] = d;
                            n_on[0]   = (d[2:0] != 3'd0) && !d[3];
                            n_psc[0]  = '0;
                        end
                        R_TBCR: begin
                            n_rf[idx] = d;
                            n_on[1]   = (d[2:0] != 3'd0);
                            n_psc[1]  = '0;
                        end
                        R_TCDCR: begin
                            n_rf[idx] = d;
                            n_on[2]   = (d[6:4] != 3'd0);
                            n_on[3]   = (d[2:0] != 3'd0);
                            n_psc[2]  = '0;
                            n_psc[3]  = '0;
                        end
                        R_RSR: begin
                            n_rf[idx] = {r_rf[idx][7:1], d[0]};
                        end
                        R_TSR: begin
                            tval = (r_rf[idx] & TSR_KEEP) | (d & TSR_WR_MASK);
                            if (d[0]) begin
                                tval = tval & ~TSR_EN_CLEAR;
                            end
                            n_rf[idx] = tval | TSR_ALWAYS;
                        end
                        default: begin
                            n_rf[idx] = d;
                        end
                    endcase
                end
            end
            FN_READ: begin
                if (!odd || (int'(idx) >= REG_COUNT)) begin
                    res.read_data = UNUSED_READ;
                end else begin
                    case (idx)
                        R_GPIP: begin
                            res.read_data = GPIP_READ_SET | (r_rf[R_GPIP] & GPIP_PIN_MASK);
                        end
                        R_TSR: begin
                            res.read_data = r_rf[R_TSR];
                            n_rf[R_TSR]   = r_rf[R_TSR] & ~TSR_READ_CLEAR;
                        end
                        R_UDR: begin
                            if (r_rf[R_RSR][7]) begin
                                n_rf[R_RSR]   = r_rf[R_RSR] & ~RSR_READ_CLEAR;
                                res.read_data = r_rf[R_UDR];
                            end
                        end
                        default: begin
                            res.read_data = r_rf[idx];
                        end
                    endcase
                end
            end
            FN_PIN: begin
                // falling edge of the level seen through the edge register
                pin_fall = (r_rf[R_GPIP][i_item.pin_index] ^ r_rf[R_AER][i_item.pin_index])
                         && !(i_item.pin_level ^ r_rf[R_AER][i_item.pin_index]);
                n_rf[R_GPIP][i_item.pin_index] = i_item.pin_level;
                if (pin_fall) begin
                    if (PIN_HAS_SRC[i_item.pin_index]) begin
                        raise[PIN_SRC[i_item.pin_index]] = 1'b1;
                    end
                    if ((i_item.pin_index == EVENT_PIN) && (r_rf[R_TACR][3:0] == TACR_EVENT)) begin
                        n_rf[R_TADR] = tmr_next(r_rf[R_TADR], r_reload[0]);
                        if (r_rf[R_TADR] == 8'd1) begin
                            raise[TIMER_SRC[0]] = 1'b1;
                        end
                    end
                end
            end
            FN_KEY: begin
                if (!r_rf[R_RSR][7]) begin
                    n_rf[R_UDR]      = d;
                    n_rf[R_RSR]      = r_rf[R_RSR] | RSR_FULL;
                    raise[SRC_RX_FULL] = 1'b1;
                    res.key_accepted = 1'b1;
                end
            end
            FN_ACK: begin
                if (act != 16'd0) begin
                    // highest-numbered active source wins
                    for (int i = 0; i < 16; i++) begin
                        if (act[i]) begin
                            hi = 4'(i);
                        end
                    end
                    res.vector       = (r_rf[R_VR] & VR_BASE_MASK) | {4'd0, hi};
                    res.vector_valid = 1'b1;
                    wrd     = {r_rf[R_IPRA], r_rf[R_IPRB]};
                    wrd[hi] = 1'b0;
                    n_rf[R_IPRA] = wrd[15:8];
                    n_rf[R_IPRB] = wrd[7:0];
                    if (r_rf[R_VR][3]) begin
                        wrd     = {r_rf[R_ISRA], r_rf[R_ISRB]};
                        wrd[hi] = 1'b1;
                        n_rf[R_ISRA] = wrd[15:8];
                        n_rf[R_ISRB] = wrd[7:0];
                    end
                end
            end
            FN_TICK: begin
                // each running timer advances its prescaler independently
                for (int ch = 0; ch < 4; ch++) begin
                    if (r_on[ch]) begin
                        cnt = r_psc[ch] + 8'd1;
                        if (cnt >= PRESCALE_DIV[codes[ch]]) begin
                            n_psc[ch] = '0;
                            n_rf[R_TADR + 5'(ch)] =
                                tmr_next(r_rf[R_TADR + 5'(ch)], r_reload[ch]);
                            if (r_rf[R_TADR + 5'(ch)] == 8'd1) begin
                                raise[TIMER_SRC[2'(ch)]] = 1'b1;
                            end
                        end else begin
                            n_psc[ch] = cnt;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        // raised sources enter pending only when enabled
        pend = {n_rf[R_IPRA], n_rf[R_IPRB]} | (raise & {r_rf[R_IERA], r_rf[R_IERB]});
        n_rf[R_IPRA] = pend[15:8];
        n_rf[R_IPRB] = pend[7:0];
        res.irq = |(pend & {n_rf[R_IMRA], n_rf[R_IMRB]} & ~{n_rf[R_ISRA], n_rf[R_ISRB]});
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf     <= RESET_TABLE;
            r_reload <= '{default: '0};
            r_psc    <= '{default: '0};
            r_on     <= '0;
        end else if (i_fire) begin
            r_rf     <= n_rf;
            r_reload <= n_reload;
            r_psc    <= n_psc;
            r_on     <= n_on;
        end
    end

    assign o_result = res;

endmodule

[design/mfp_out_stage.sv]
// ----------------------------------------------------------------------------
// mfp_out_stage
// Result register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module mfp_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  mfp_pkg::t_result i_result,
    input  logic             i_out_stall,
    output logic             o_ready,
    output logic             o_out_valid,
    output mfp_pkg::t_result o_result
);
    import mfp_pkg::*;

    logic    r_valid;
    t_result r_result;

    // room when empty or when the held beat leaves this cycle
    assign o_ready = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_load || (r_valid && i_out_stall);
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;

endmodule

[design/mfp_checker.sv]
// ----------------------------------------------------------------------------
// mfp_checker
// Port-level checks of the multi-function peripheral, bound to the top level.
// ----------------------------------------------------------------------------
module mfp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_read_data,
    input logic       o_out_key_accepted,
    input logic [7:0] o_out_vector,
    input logic       o_out_vector_valid
);

    // both channels come up empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("channels not empty after reset");

    // stalled result beat keeps its vector
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_vector))
        else $error("stalled result beat changed");

    // a beat without a valid vector carries a zero vector
    a_autovec_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_vector_valid |-> o_out_vector == 8'h00)
        else $error("vector set without a valid source");

    // a key-accepted beat carries neither read data nor a valid vector
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_key_accepted |-> !o_out_vector_valid
            && o_out_read_data == 8'h00)
        else $error("key beat carries read or vector data");

endmodule

bind multifunction_peripheral_irq_timers mfp_checker u_mfp_checker (.*);
